FILE: hw/rtl/gpta_pkg.sv
package gpta_pkg;

  // run length and table geometry
  localparam int MAX_BYTES        = 256;
  localparam int ENTRIES_PER_BYTE = 32;
  localparam int TABLE_DEPTH      = MAX_BYTES * ENTRIES_PER_BYTE;
  localparam int POS_W            = $clog2(MAX_BYTES);

  // one lane per 2-bit genotype slot, each with its own bank of 8 classes per byte
  localparam int LANES      = 4;
  localparam int CLASSES    = 8;
  localparam int BANK_DEPTH = MAX_BYTES * CLASSES;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam int ADDR_W  = 13;
  localparam int VALUE_W = 32;
  localparam int GENO_W  = 8;
  localparam int SUM_W   = 43;
  localparam int MISS_W  = 11;
  localparam int BSUM_W  = VALUE_W + 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PAIR  = 1'b1;

  typedef struct packed {
    logic               miss;
    logic signed [31:0] data;
  } lane_rd_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic wrap;
  } gpta_ctl_t;

endpackage

FILE: hw/rtl/gpta_in_if.sv
interface gpta_in_if import gpta_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [ADDR_W-1:0]         table_addr;
  logic signed [VALUE_W-1:0] table_value;
  logic [GENO_W-1:0]         geno_i;
  logic [GENO_W-1:0]         geno_j;
  logic                      last;

  modport source (output valid, opcode, table_addr, table_value, geno_i, geno_j, last,
                  input ready);
  modport sink   (input valid, opcode, table_addr, table_value, geno_i, geno_j, last,
                  output ready);
endinterface

FILE: hw/rtl/gpta_out_if.sv
interface gpta_out_if import gpta_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] product_sum;
  logic [MISS_W-1:0]       missing_count;
  logic                    position_overflow;

  modport source (output valid, product_sum, missing_count, position_overflow,
                  input ready);
  modport sink   (input valid, product_sum, missing_count, position_overflow,
                  output ready);
endinterface

FILE: hw/rtl/gpta_lane.sv
module gpta_lane import gpta_pkg::*; (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [BANK_AW-1:0]        wr_idx_i,
  input  logic signed [VALUE_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [POS_W-1:0]          pos_i,
  input  logic [1:0]                geno_a_i,
  input  logic [1:0]                geno_b_i,
  output lane_rd_t                  rd_o
);

  logic signed [VALUE_W-1:0] mem_q [BANK_DEPTH];
  logic [1:0]         g_or;
  logic [1:0]         g_and;
  logic               miss;
  logic [2:0]         cls;
  logic [BANK_AW-1:0] rd_idx;
  lane_rd_t           rd_q;

  // class: bit0 = or[0], bit1 = any and bit or missing, bit2 = or[1]
  always_comb begin
    g_or   = geno_a_i | geno_b_i;
    g_and  = geno_a_i & geno_b_i;
    miss   = (geno_a_i == 2'b11) || (geno_b_i == 2'b11);
    cls    = {g_or[1], g_and[0] | g_and[1] | miss, g_or[0]};
    rd_idx = {pos_i, cls};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q.data <= mem_q[rd_idx];
      rd_q.miss <= miss;
    end
  end

  assign rd_o = rd_q;

endmodule

FILE: hw/rtl/gpta_merge.sv
module gpta_merge import gpta_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  gpta_ctl_t               ctl_i,
  input  lane_rd_t                lanes_i [LANES],
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [SUM_W-1:0] product_sum_o,
  output logic [MISS_W-1:0]       missing_count_o,
  output logic                    position_overflow_o
);

  gpta_ctl_t                ctl_a_q;
  logic signed [BSUM_W-1:0] bsum_d, bsum_q;
  logic [2:0]               bmiss_d, bmiss_q;

  logic signed [SUM_W-1:0]  acc_q, acc_sat;
  logic signed [SUM_W:0]    acc_ext;
  logic [MISS_W-1:0]        miss_q, miss_sat;
  logic [MISS_W:0]          miss_ext;

  logic                     out_valid_q;
  logic signed [SUM_W-1:0]  out_sum_q;
  logic [MISS_W-1:0]        out_miss_q;
  logic                     out_wrap_q;

  // merge: four lane entries and missing flags
  always_comb begin
    bsum_d  = '0;
    bmiss_d = '0;
    for (int l = 0; l < LANES; l++) begin
      bsum_d  = bsum_d + BSUM_W'(lanes_i[l].data);
      bmiss_d = bmiss_d + 3'(lanes_i[l].miss);
    end
  end

  // accumulate with saturation
  always_comb begin
    acc_ext  = (SUM_W+1)'(acc_q) + (SUM_W+1)'(bsum_q);
    acc_sat  = acc_ext[SUM_W-1:0];
    if (acc_ext[SUM_W] != acc_ext[SUM_W-1]) begin
      acc_sat = acc_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    miss_ext = {1'b0, miss_q} + (MISS_W+1)'(bmiss_q);
    miss_sat = miss_ext[MISS_W] ? {MISS_W{1'b1}} : miss_ext[MISS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q     <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_i) begin
        ctl_a_q <= ctl_i;
        if (ctl_a_q.valid) begin
          if (ctl_a_q.last) begin
            acc_q  <= '0;
            miss_q <= '0;
          end else begin
            acc_q  <= acc_sat;
            miss_q <= miss_sat;
          end
        end
      end
      if (adv_i && ctl_a_q.valid && ctl_a_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bsum_q  <= bsum_d;
      bmiss_q <= bmiss_d;
      if (ctl_a_q.valid && ctl_a_q.last) begin
        out_sum_q  <= acc_sat;
        out_miss_q <= miss_sat;
        out_wrap_q <= ctl_a_q.wrap;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign product_sum_o       = out_sum_q;
  assign missing_count_o     = out_miss_q;
  assign position_overflow_o = out_wrap_q;

endmodule

FILE: hw/rtl/genotype_pair_table_accumulate.sv
// Genotype pair table accumulator. Write requests (opcode write) load one signed Q8.24 entry
// of the product table; every entry a run reads must be written first. Pair requests carry one
// byte of four 2-bit genotypes per individual; each slot picks one of eight entries for the
// current byte position, and the run's sum (saturating, 43 bits) and missing count (saturating
// at 2047) are returned as one result after the request marked last, after which the run state
// clears while the table is kept. One request is taken per cycle as long as results are taken;
// a result passes through the registered bank read, lane merge and accumulate stages before
// it is valid in the output register.
// A result held in the output register and not taken stalls the whole pipeline and input.
module genotype_pair_table_accumulate import gpta_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gpta_in_if.sink    req_i,
  gpta_out_if.source res_o
);

  logic             adv;
  logic             accept;
  logic             pair_acc;
  logic             wr_ok;
  logic [1:0]       wr_slot;
  logic [BANK_AW-1:0] wr_idx;
  logic [POS_W-1:0] pos_d, pos_q;
  logic             wrap_d, wrap_q;
  logic             at_end;
  gpta_ctl_t        ctl_d, ctl_q;
  lane_rd_t         lane_rd [LANES];

  // whole pipeline moves unless a finished result is waiting
  assign adv         = !res_o.valid || res_o.ready;
  assign req_i.ready = adv;
  assign accept      = req_i.valid && req_i.ready;
  assign pair_acc    = accept && (req_i.opcode == OP_PAIR);

  // write address: position | slot | class; slot selects the bank
  always_comb begin
    wr_ok   = ({1'b0, req_i.table_addr} < (ADDR_W+1)'(TABLE_DEPTH));
    wr_slot = req_i.table_addr[4:3];
    wr_idx  = {req_i.table_addr[POS_W+4:5], req_i.table_addr[2:0]};
  end

  // byte position and wrap tracking, done at accept so the lanes can address the banks
  always_comb begin
    at_end = (pos_q == POS_W'(MAX_BYTES - 1));
    pos_d  = pos_q;
    wrap_d = wrap_q;
    ctl_d  = '0;
    if (adv) begin
      ctl_d.valid = pair_acc;
      ctl_d.last  = req_i.last;
      ctl_d.wrap  = wrap_q | at_end;
    end else begin
      ctl_d = ctl_q;
    end
    if (pair_acc) begin
      if (req_i.last) begin
        pos_d  = '0;
        wrap_d = 1'b0;
      end else if (at_end) begin
        pos_d  = '0;
        wrap_d = 1'b1;
      end else begin
        pos_d  = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wrap_q <= 1'b0;
      ctl_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      wrap_q <= wrap_d;
      ctl_q  <= ctl_d;
    end
  end

  // one lane per genotype slot
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    gpta_lane u_lane (
      .clk_i     (clk_i),
      .wr_en_i   (accept && (req_i.opcode == OP_WRITE) && wr_ok && (wr_slot == 2'(l))),
      .wr_idx_i  (wr_idx),
      .wr_data_i (req_i.table_value),
      .rd_en_i   (pair_acc),
      .pos_i     (pos_q),
      .geno_a_i  (req_i.geno_i[2*l +: 2]),
      .geno_b_i  (req_i.geno_j[2*l +: 2]),
      .rd_o      (lane_rd[l])
    );
  end

  gpta_merge u_merge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .adv_i               (adv),
    .ctl_i               (ctl_q),
    .lanes_i             (lane_rd),
    .out_ready_i         (res_o.ready),
    .out_valid_o         (res_o.valid),
    .product_sum_o       (res_o.product_sum),
    .missing_count_o     (res_o.missing_count),
    .position_overflow_o (res_o.position_overflow)
  );

`ifndef SYNTHESIS
  a_pos_clears_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_acc && req_i.last |=> (pos_q == '0) && !wrap_q)
    else $error("byte position not cleared after last request");

  a_write_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.opcode == OP_WRITE) |=> $stable(pos_q) && $stable(wrap_q))
    else $error("table write moved run state");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.product_sum) &&
      $stable(res_o.missing_count) && $stable(res_o.position_overflow))
    else $error("waiting result changed or dropped");
`endif

endmodule

FILE: tb/sv/genotype_pair_table_accumulate_test.sv
module genotype_pair_table_accumulate_test;
  import gpta_pkg::*;

  // stimulus size: requests queued in all, writes included
  localparam int ITEM_COUNT    = 1050;
  // pacing
  localparam int GAP_MAX       = 11;
  localparam int PRESSURE_AT   = 10;    // results taken before the long hold-off
  localparam int PRESSURE_HOLD = 400;
  localparam int STALL_LIMIT   = 4000;  // cycles without any handshake
  localparam int DRAIN_CYCLES  = 16;
  localparam int MAX_SHOWN     = 10;

  localparam longint      SUM_HI   = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint      SUM_LO   = -SUM_HI - 1;
  localparam int unsigned MISS_CAP = (1 << MISS_W) - 1;

  typedef struct packed {
    logic                      opcode;
    logic [ADDR_W-1:0]         table_addr;
    logic signed [VALUE_W-1:0] table_value;
    logic [GENO_W-1:0]         geno_i;
    logic [GENO_W-1:0]         geno_j;
    logic                      last;
  } gpta_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] product_sum;
    logic [MISS_W-1:0]       missing_count;
    logic                    position_overflow;
  } run_total_t;

  logic clk_i;
  logic rst_ni;

  gpta_in_if  req_if ();
  gpta_out_if res_if ();

  genotype_pair_table_accumulate DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: shadow product table and the open run
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] shadow_tbl [TABLE_DEPTH];
  longint                    run_sum;
  int unsigned               run_miss;
  int unsigned               run_pos;
  bit                        run_wrap;
  run_total_t                totals_due [$];   // run totals still owed by the block

  // request generation: which entries are loaded, and the byte position the next pair lands on
  bit          filled [TABLE_DEPTH];
  int unsigned gen_pos;
  int unsigned queued;
  gpta_req_t   pending [$];

  // handshake bookkeeping shared between the edge processes
  gpta_req_t   on_bus;
  gpta_req_t   seen_req;
  run_total_t  seen_total;
  bit          presenting;
  bit          req_taken;
  bit          total_taken;
  bit          send_calm;
  bit          recv_calm;
  int          send_gap;
  int          recv_hold;
  int          totals_seen;
  int          quiet;
  int          errors;

  // 3-bit class of one genotype slot pair; a missing genotype forces the middle bit
  function automatic logic [2:0] pair_class(logic [1:0] a, logic [1:0] b);
    logic [1:0] either_bits;
    logic [1:0] shared_bits;
    logic       absent;
    either_bits = a | b;
    shared_bits = a & b;
    absent      = (a == 2'd3) || (b == 2'd3);
    return {either_bits[1], (|shared_bits) | absent, either_bits[0]};
  endfunction

  // fold one accepted request into the shadow state; a last pair closes the run
  task automatic fold_request(input gpta_req_t r);
    longint      byte_sum;
    int unsigned byte_miss;
    logic [1:0]  a;
    logic [1:0]  b;
    byte_sum  = 0;
    byte_miss = 0;
    if (r.opcode == OP_WRITE) begin
      if (r.table_addr < TABLE_DEPTH) shadow_tbl[r.table_addr] = r.table_value;
      return;
    end
    for (int s = 0; s < LANES; s++) begin
      a = r.geno_i[2*s +: 2];
      b = r.geno_j[2*s +: 2];
      if (a == 2'd3 || b == 2'd3) byte_miss++;
      byte_sum += longint'(shadow_tbl[run_pos*ENTRIES_PER_BYTE + s*CLASSES + pair_class(a, b)]);
    end
    run_sum += byte_sum;
    if (run_sum > SUM_HI) run_sum = SUM_HI;
    if (run_sum < SUM_LO) run_sum = SUM_LO;
    run_miss += byte_miss;
    if (run_miss > MISS_CAP) run_miss = MISS_CAP;
    run_pos++;
    if (run_pos >= MAX_BYTES) begin
      run_pos  = 0;
      run_wrap = 1'b1;
    end
    if (r.last) begin
      totals_due.push_back('{product_sum: run_sum[SUM_W-1:0],
                             missing_count: run_miss[MISS_W-1:0],
                             position_overflow: run_wrap});
      run_sum  = 0;
      run_miss = 0;
      run_pos  = 0;
      run_wrap = 1'b0;
    end
  endtask

  task automatic check_total(input run_total_t got);
    run_total_t want;
    if (totals_due.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("unexpected result: sum %0d missing %0d wrap %0b",
                 got.product_sum, got.missing_count, got.position_overflow);
      return;
    end
    want = totals_due.pop_front();
    if (got.product_sum !== want.product_sum || got.missing_count !== want.missing_count ||
        got.position_overflow !== want.position_overflow) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("result mismatch: sum %0d/%0d missing %0d/%0d wrap %0b/%0b (expected/actual)",
                 want.product_sum, got.product_sum, want.missing_count, got.missing_count,
                 want.position_overflow, got.position_overflow);
    end
  endtask

  // wait cycles after each request or result; calm stretches with no idling come and go
  function automatic int idle_draw(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [VALUE_W-1:0] table_word();
    case ($urandom_range(0, 7))
      0: begin
        return {1'b0, {(VALUE_W-1){1'b1}}};
      end
      1: begin
        return {1'b1, {(VALUE_W-1){1'b0}}};
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [GENO_W-1:0] geno_byte();
    case ($urandom_range(0, 7))
      0: begin
        return 8'hFF;
      end
      1: begin
        return 8'h00;
      end
      default: begin
        return GENO_W'($urandom);
      end
    endcase
  endfunction

  task automatic push_write(input int unsigned addr, input logic [VALUE_W-1:0] value,
                            input logic last_b);
    gpta_req_t r;
    r.opcode      = OP_WRITE;
    r.table_addr  = addr[ADDR_W-1:0];
    r.table_value = value;
    r.geno_i      = GENO_W'($urandom);
    r.geno_j      = GENO_W'($urandom);
    r.last        = last_b;   // no effect on a write
    pending.push_back(r);
    filled[addr] = 1'b1;
    queued++;
  endtask

  // queue a pair request, loading first any entry it reads that was never written
  task automatic push_pair(input logic [GENO_W-1:0] gi, input logic [GENO_W-1:0] gj,
                           input logic last_b);
    gpta_req_t   r;
    int unsigned addr;
    for (int s = 0; s < LANES; s++) begin
      addr = gen_pos*ENTRIES_PER_BYTE + s*CLASSES + pair_class(gi[2*s +: 2], gj[2*s +: 2]);
      if (!filled[addr]) push_write(addr, table_word(), 1'($urandom_range(0, 1)));
    end
    r.opcode      = OP_PAIR;
    r.table_addr  = ADDR_W'($urandom);
    r.table_value = $urandom;
    r.geno_i      = gi;
    r.geno_j      = gj;
    r.last        = last_b;
    pending.push_back(r);
    gen_pos = last_b ? 0 : (gen_pos + 1) % MAX_BYTES;
    queued++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          run_len;
    int unsigned stop_at;

    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_WRITE;
    req_if.table_addr   = '0;
    req_if.table_value  = '0;
    req_if.geno_i       = '0;
    req_if.geno_j       = '0;
    req_if.last         = 1'b0;
    res_if.ready        = 1'b0;
    on_bus              = '0;
    run_sum             = 0;
    run_miss            = 0;
    run_pos             = 0;
    run_wrap            = 1'b0;
    gen_pos             = 0;
    queued              = 0;
    presenting          = 1'b0;
    req_taken           = 1'b0;
    total_taken         = 1'b0;
    send_calm           = 1'b0;
    recv_calm           = 1'b0;
    send_gap            = 0;
    recv_hold           = 0;
    totals_seen         = 0;
    quiet               = 0;
    errors              = 0;
    foreach (filled[k]) filled[k] = 1'b0;

    // Directed: all sixteen genotype pairs over a four-byte run (first individual constant per
    // byte, second 0..3 across slots), with writes slipped in mid-run, one of them marked last
    // and hitting the top address, the other overwriting an entry already read.
    push_pair(8'h00, 8'hE4, 1'b0);
    push_write(TABLE_DEPTH - 1, 32'h7FFF_FFFF, 1'b1);
    push_pair(8'h55, 8'hE4, 1'b0);
    push_write(0, 32'h8000_0000, 1'b0);
    push_pair(8'hAA, 8'hE4, 1'b0);
    push_pair(8'hFF, 8'hE4, 1'b1);
    push_pair(8'h1B, 8'hFF, 1'b1);    // single-byte run, every slot missing

    // Random runs: mostly short, now and then longer, with stray writes anywhere in the table
    stop_at = ITEM_COUNT;
    while (queued < stop_at) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 5) == 0)
          push_write($urandom_range(0, TABLE_DEPTH - 1), table_word(),
                     1'($urandom_range(0, 1)));
        push_pair(geno_byte(), geno_byte(), k == run_len - 1);
      end
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || presenting) @(posedge clk_i);
    while (totals_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && totals_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: changes on the falling edge, one request on the bus at a time
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        presenting = 1'b0;
        req_taken  = 1'b0;
        send_gap   = idle_draw(send_calm);
      end
      if (!presenting && pending.size() != 0) begin
        if (send_gap == 0) begin
          on_bus     = pending.pop_front();
          presenting = 1'b1;
        end else begin
          send_gap--;
        end
      end
      req_if.valid       <= presenting;
      req_if.opcode      <= on_bus.opcode;
      req_if.table_addr  <= on_bus.table_addr;
      req_if.table_value <= on_bus.table_value;
      req_if.geno_i      <= on_bus.geno_i;
      req_if.geno_j      <= on_bus.geno_j;
      req_if.last        <= on_bus.last;
    end
  end

  // Result receiver: random wait after each result; one long hold-off lets the pipeline back
  // up into the request side while the driver keeps offering.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (total_taken) begin
        total_taken = 1'b0;
        recv_hold   = (totals_seen == PRESSURE_AT) ? PRESSURE_HOLD : idle_draw(recv_calm);
      end
      if (recv_hold != 0) begin
        recv_hold--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: handshakes sampled on the rising edge, plus the stall watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen_req.opcode      = req_if.opcode;
        seen_req.table_addr  = req_if.table_addr;
        seen_req.table_value = req_if.table_value;
        seen_req.geno_i      = req_if.geno_i;
        seen_req.geno_j      = req_if.geno_j;
        seen_req.last        = req_if.last;
        fold_request(seen_req);
        req_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        seen_total.product_sum       = res_if.product_sum;
        seen_total.missing_count     = res_if.missing_count;
        seen_total.position_overflow = res_if.position_overflow;
        check_total(seen_total);
        total_taken = 1'b1;
        totals_seen++;
      end
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
hw/rtl/gpta_pkg.sv
hw/rtl/gpta_in_if.sv
hw/rtl/gpta_out_if.sv
hw/rtl/gpta_lane.sv
hw/rtl/gpta_merge.sv
hw/rtl/genotype_pair_table_accumulate.sv
tb/sv/genotype_pair_table_accumulate_test.sv
